// ===== src/tcpts_pkg.sv =====
// Shared constants for the TCP timestamp option finder.
`timescale 1ns / 1ps
package tcpts_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_FIXED = 3'd0;
  localparam logic [2:0] PH_KIND  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_TS    = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // Header geometry
  localparam logic [5:0] MIN_HDR     = 6'd20;
  localparam logic [5:0] POS_MAX     = 6'd63;
  localparam logic [5:0] OFFSET_POS  = 6'd12;
  localparam logic [5:0] TRUNC_MIN   = 6'd13;

  // Option codes
  localparam logic [7:0] OPT_EOL     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_TS      = 8'd8;
  localparam logic [7:0] TS_LEN      = 8'd10;
  localparam logic [7:0] TS_BODY     = 8'd8;
  localparam logic [7:0] TS_HALF     = 8'd4;
  localparam logic [7:0] OPT_MIN_LEN = 8'd2;

endpackage

// ===== src/tcp_timestamp_option_finder.sv =====
// Byte-serial TCP option walker that extracts the timestamp option.
// The result is registered when the last byte of a segment is transferred and appears in the cycle after.
// Throughput: one byte per cycle while the input is not stalled; the option walk is a single state update per byte.
// Input stalls only when a last byte arrives while the previous result is still held.
// Reset (rst, synchronous): parser returns to the fixed header phase, no result pending.
// The parser also returns to its reset state after every segment's last byte.
`timescale 1ns / 1ps
module tcp_timestamp_option_finder
  import tcpts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] ts_value,
  output logic [31:0] ts_echo,
  output logic        short_packet,
  output logic        truncated
);

  // Parser state
  logic [5:0]  byte_position;
  logic [5:0]  header_end;
  logic [2:0]  parse_phase;
  logic [7:0]  option_kind;
  logic [7:0]  skip_remaining;
  logic [31:0] value_shift;
  logic [31:0] echo_shift;
  logic        found_flag;

  logic [5:0]  header_end_next;
  logic [2:0]  parse_phase_next;
  logic [7:0]  option_kind_next;
  logic [7:0]  skip_remaining_next;
  logic [31:0] value_shift_next;
  logic [31:0] echo_shift_next;
  logic        found_flag_next;
  logic [5:0]  length;
  logic [7:0]  skip_dec;
  logic        in_xfer;

  // Hold a last byte only while the prior result still waits
  assign in_stall = out_valid && out_stall && last_byte;
  assign in_xfer  = in_valid && !in_stall;

  assign length   = (byte_position < POS_MAX) ? byte_position + 6'd1 : POS_MAX;
  assign skip_dec = (skip_remaining != 8'd0) ? skip_remaining - 8'd1 : skip_remaining;

  // Advance the option walk by one byte
  always_comb begin
    header_end_next     = header_end;
    parse_phase_next    = parse_phase;
    option_kind_next    = option_kind;
    skip_remaining_next = skip_remaining;
    value_shift_next    = value_shift;
    echo_shift_next     = echo_shift;
    found_flag_next     = found_flag;

    if (byte_position == OFFSET_POS) begin
      header_end_next = {data_byte[7:4], 2'b00};
    end

    case (parse_phase)
      PH_FIXED: begin
        if (byte_position == MIN_HDR - 6'd1) begin
          parse_phase_next = PH_KIND;
        end
      end
      PH_KIND: begin
        if (byte_position >= header_end_next || data_byte == OPT_EOL) begin
          parse_phase_next = PH_DONE;
        end else if (data_byte != OPT_NOP) begin
          option_kind_next = data_byte;
          parse_phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (byte_position >= header_end_next) begin
          parse_phase_next = PH_DONE;
        end else if (option_kind == OPT_TS && data_byte == TS_LEN &&
                     ({1'b0, byte_position} + 7'd8) < {1'b0, header_end_next}) begin
          skip_remaining_next = TS_BODY;
          value_shift_next    = '0;
          echo_shift_next     = '0;
          parse_phase_next    = PH_TS;
        end else if (data_byte >= OPT_MIN_LEN) begin
          skip_remaining_next = data_byte - OPT_MIN_LEN;
          parse_phase_next    = (data_byte == OPT_MIN_LEN) ? PH_KIND : PH_SKIP;
        end else begin
          parse_phase_next = PH_DONE;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 8'd0) begin
          parse_phase_next = PH_KIND;
        end
      end
      PH_TS: begin
        if (skip_remaining > TS_HALF) begin
          value_shift_next = {value_shift[23:0], data_byte};
        end else begin
          echo_shift_next = {echo_shift[23:0], data_byte};
        end
        skip_remaining_next = skip_dec;
        if (skip_dec == 8'd0) begin
          found_flag_next  = 1'b1;
          parse_phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Update parser state; clear it after each segment
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && last_byte)) begin
      byte_position  <= '0;
      header_end     <= '0;
      parse_phase    <= PH_FIXED;
      option_kind    <= '0;
      skip_remaining <= '0;
      value_shift    <= '0;
      echo_shift     <= '0;
      found_flag     <= 1'b0;
    end else if (in_xfer) begin
      byte_position  <= length;
      header_end     <= header_end_next;
      parse_phase    <= parse_phase_next;
      option_kind    <= option_kind_next;
      skip_remaining <= skip_remaining_next;
      value_shift    <= value_shift_next;
      echo_shift     <= echo_shift_next;
      found_flag     <= found_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      found        <= found_flag_next;
      ts_value     <= found_flag_next ? value_shift_next : '0;
      ts_echo      <= found_flag_next ? echo_shift_next : '0;
      short_packet <= (length < MIN_HDR);
      truncated    <= (length < TRUNC_MIN) || (length < header_end_next);
    end
  end

endmodule

// ===== src/tcp_timestamp_option_finder_checker.sv =====
// Port-level checks for the TCP timestamp option finder, bound to the top level.
`timescale 1ns / 1ps
module tcp_timestamp_option_finder_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [31:0] ts_value,
  input logic [31:0] ts_echo,
  input logic        short_packet
);

  // No result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A last-byte transfer yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("segment end without result");

  // Fields are zero when no timestamp was found
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> ts_value == 32'd0 && ts_echo == 32'd0)
    else $error("timestamp fields set without found");

  // A found timestamp implies a full fixed header
  assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !short_packet)
    else $error("found on short packet");

  // Held result stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ts_value) && $stable(found))
    else $error("stalled result changed");

endmodule

bind tcp_timestamp_option_finder tcp_timestamp_option_finder_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_byte    (last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .ts_value     (ts_value),
  .ts_echo      (ts_echo),
  .short_packet (short_packet)
);

// ===== tb/tb_top.sv =====
// Testbench for the TCP timestamp option finder: directed and random segments, self-checking.
`timescale 1ns / 1ps
module tb_top;
  import tcpts_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
    logic [31:0] echo;
    logic        short_pkt;
    logic        trunc;
  } ts_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic        short_packet;
  logic        truncated;

  // Shadow parser state
  logic [5:0]  seen_pos;
  logic [5:0]  hdr_end;
  logic [2:0]  walk_phase;
  logic [7:0]  cur_kind;
  logic [7:0]  bytes_left;
  logic [31:0] value_acc;
  logic [31:0] echo_acc;
  logic        ts_captured;

  ts_report_t  expected_reports[$];
  ts_report_t  want;
  logic [7:0]  seg[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet_sender = 1'b0;
  bit  quiet_receiver = 1'b0;
  bit  long_hold_pending = 1'b0;

  tcp_timestamp_option_finder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .ts_value     (ts_value),
    .ts_echo      (ts_echo),
    .short_packet (short_packet),
    .truncated    (truncated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic clear_tracker();
    seen_pos    = 6'd0;
    hdr_end     = 6'd0;
    walk_phase  = PH_FIXED;
    cur_kind    = 8'd0;
    bytes_left  = 8'd0;
    value_acc   = 32'd0;
    echo_acc    = 32'd0;
    ts_captured = 1'b0;
  endtask

  // Advance the shadow parser by one byte; queue a report on the last byte
  task automatic track_byte(input logic [7:0] b, input logic l);
    logic [5:0] p;
    logic [5:0] seg_len;
    ts_report_t r;
    p = seen_pos;
    if (p == OFFSET_POS) hdr_end = {b[7:4], 2'b00};
    case (walk_phase)
      PH_FIXED: begin
        if (p == MIN_HDR - 6'd1) walk_phase = PH_KIND;
      end
      PH_KIND: begin
        if (p >= hdr_end || b == OPT_EOL) begin
          walk_phase = PH_DONE;
        end else if (b != OPT_NOP) begin
          cur_kind = b;
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (p >= hdr_end) begin
          walk_phase = PH_DONE;
        end else if (cur_kind == OPT_TS && b == TS_LEN &&
                     int'(p) + int'(TS_BODY) < int'(hdr_end)) begin
          bytes_left = TS_BODY;
          value_acc  = 32'd0;
          echo_acc   = 32'd0;
          walk_phase = PH_TS;
        end else if (b >= OPT_MIN_LEN) begin
          bytes_left = b - OPT_MIN_LEN;
          walk_phase = (bytes_left == 8'd0) ? PH_KIND : PH_SKIP;
        end else begin
          walk_phase = PH_DONE;
        end
      end
      PH_SKIP: begin
        if (bytes_left > 8'd0) bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) walk_phase = PH_KIND;
      end
      PH_TS: begin
        if (bytes_left > TS_HALF) value_acc = {value_acc[23:0], b};
        else echo_acc = {echo_acc[23:0], b};
        if (bytes_left > 8'd0) bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          ts_captured = 1'b1;
          walk_phase  = PH_DONE;
        end
      end
      default: ;
    endcase
    seg_len  = (p < POS_MAX) ? p + 6'd1 : POS_MAX;
    seen_pos = seg_len;
    if (l) begin
      r.found     = ts_captured;
      r.value     = ts_captured ? value_acc : 32'd0;
      r.echo      = ts_captured ? echo_acc : 32'd0;
      r.short_pkt = (seg_len < MIN_HDR);
      r.trunc     = (seg_len < TRUNC_MIN) || (seg_len < hdr_end);
      expected_reports.push_back(r);
      clear_tracker();
    end
  endtask

  // Offer one byte and hold it until the transfer happens
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, l);
  endtask

  task automatic send_segment();
    for (int i = 0; i < seg.size(); i++) send_byte(seg[i], i == seg.size() - 1);
  endtask

  // Start a segment with a 20-byte fixed header; byte 12 carries the offset
  task automatic begin_header(input logic [7:0] off_byte);
    seg.delete();
    for (int i = 0; i < int'(MIN_HDR); i++)
      seg.push_back((i == int'(OFFSET_POS)) ? off_byte : 8'($urandom_range(0, 255)));
  endtask

  task automatic add_timestamp(input logic [31:0] v, input logic [31:0] e);
    seg.push_back(OPT_TS);
    seg.push_back(TS_LEN);
    for (int i = 3; i >= 0; i--) seg.push_back(v[8*i +: 8]);
    for (int i = 3; i >= 0; i--) seg.push_back(e[8*i +: 8]);
  endtask

  task automatic pad_to(input int n, input logic [7:0] b);
    while (seg.size() < n) seg.push_back(b);
  endtask

  // Segments that end inside the fixed header
  task automatic test_short_segments();
    seg.delete();
    seg.push_back(8'hFF);
    send_segment();
    seg.delete();
    pad_to(12, 8'h00);
    send_segment();
    begin_header(8'hF0);
    while (seg.size() > 13) void'(seg.pop_back());
    send_segment();
    begin_header(8'h50);
    void'(seg.pop_back());
    send_segment();
  endtask

  // Timestamp found with extreme values; reserved bits set in the offset byte
  task automatic test_timestamp_basic();
    begin_header(8'h8F);
    seg.push_back(OPT_NOP);
    seg.push_back(OPT_NOP);
    add_timestamp(32'hFFFF_FFFF, 32'h0000_0000);
    send_segment();
    begin_header(8'h80);
    add_timestamp(32'h0000_0000, 32'hFFFF_FFFF);
    pad_to(32, OPT_NOP);
    pad_to(35, 8'hFF);
    send_segment();
  endtask

  // End-of-list, skips, bad lengths, a misfit timestamp, small offsets
  task automatic test_option_walk();
    begin_header(8'h80);
    seg.push_back(OPT_EOL);
    add_timestamp($urandom, $urandom);
    send_segment();
    begin_header(8'hA0);
    seg.push_back(8'hFE);
    seg.push_back(8'd6);
    pad_to(26, 8'hA5);
    add_timestamp($urandom, $urandom);
    pad_to(40, OPT_NOP);
    send_segment();
    // Timestamp that does not fit inside the header
    begin_header(8'h80);
    pad_to(23, OPT_NOP);
    add_timestamp($urandom, $urandom);
    send_segment();
    begin_header(8'h80);
    seg.push_back(8'd5);
    seg.push_back(8'd1);
    add_timestamp($urandom, $urandom);
    send_segment();
    // Data offset below five
    begin_header(8'h40);
    add_timestamp($urandom, $urandom);
    send_segment();
    // Option that runs past the header end
    begin_header(8'h60);
    seg.push_back(8'd3);
    seg.push_back(8'd12);
    pad_to(32, 8'h5A);
    add_timestamp($urandom, $urandom);
    send_segment();
  endtask

  // Timestamp cut off by the segment end, and one captured in a cut header
  task automatic test_timestamp_cut();
    begin_header(8'h80);
    seg.push_back(OPT_NOP);
    seg.push_back(OPT_NOP);
    add_timestamp($urandom, $urandom);
    while (seg.size() > 28) void'(seg.pop_back());
    send_segment();
    begin_header(8'hF0);
    add_timestamp($urandom, $urandom);
    send_segment();
  endtask

  // Segment longer than the saturating byte position
  task automatic test_long_segment();
    begin_header(8'hF3);
    add_timestamp($urandom, $urandom);
    while (seg.size() < 70) seg.push_back(8'($urandom_range(0, 255)));
    send_segment();
  endtask

  // Hold the result side off while short segments keep arriving
  task automatic test_backpressure();
    quiet_sender = 1'b1;
    long_hold_pending = 1'b1;
    repeat (6) begin
      seg.delete();
      seg.push_back(8'($urandom_range(0, 255)));
      seg.push_back(8'($urandom_range(0, 255)));
      send_segment();
    end
    quiet_sender = 1'b0;
  endtask

  // Mostly well-formed segments with random content, some noise and cuts
  task automatic test_random_traffic();
    int sent_bytes;
    int segs;
    int pick;
    int hdr;
    int plen;
    int cut;
    logic [3:0] nib;
    logic [3:0] low_bits;
    logic [7:0] k;
    logic [7:0] ln;
    sent_bytes = 0;
    segs = 0;
    while (sent_bytes < 590) begin
      quiet_sender   = (segs % 10) < 2;
      quiet_receiver = (segs % 10) < 2;
      if ($urandom_range(0, 99) < 8) begin
        seg.delete();
        repeat ($urandom_range(1, 30)) seg.push_back(8'($urandom_range(0, 255)));
      end else begin
        nib = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(5, 15))
                                           : 4'($urandom_range(0, 4));
        low_bits = 4'($urandom_range(0, 15));
        begin_header({nib, low_bits});
        hdr = int'(nib) * 4;
        // Fill the option area
        while (seg.size() < hdr) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            seg.push_back(OPT_NOP);
          end else if (pick < 20) begin
            seg.push_back(OPT_EOL);
          end else if (pick < 50) begin
            add_timestamp($urandom, $urandom);
          end else if (pick < 88) begin
            k  = 8'($urandom_range(2, 255));
            ln = 8'($urandom_range(2, 8));
            seg.push_back(k);
            seg.push_back(ln);
            repeat (int'(ln) - 2) seg.push_back(8'($urandom_range(0, 255)));
          end else begin
            seg.push_back(8'($urandom_range(0, 255)));
            seg.push_back(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 1))
                                                      : 8'($urandom_range(0, 255)));
          end
        end
        plen = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 8) : $urandom_range(20, 50);
        repeat (plen) seg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 20) begin
          cut = $urandom_range(1, seg.size());
          while (seg.size() > cut) void'(seg.pop_back());
        end
      end
      sent_bytes += seg.size();
      segs++;
      send_segment();
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // Drive the result-side stall: a requested long hold, else random gaps
  always @(posedge clk) begin
    if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = quiet_receiver ? 0 : pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expected report
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result with no report expected");
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          fail_count++;
        end
        if (ts_value !== want.value) begin
          $error("ts_value: expected %h, actual %h", want.value, ts_value);
          fail_count++;
        end
        if (ts_echo !== want.echo) begin
          $error("ts_echo: expected %h, actual %h", want.echo, ts_echo);
          fail_count++;
        end
        if (short_packet !== want.short_pkt) begin
          $error("short_packet: expected %0d, actual %0d", want.short_pkt, short_packet);
          fail_count++;
        end
        if (truncated !== want.trunc) begin
          $error("truncated: expected %0d, actual %0d", want.trunc, truncated);
          fail_count++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clear_tracker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_segments();
    test_timestamp_basic();
    test_option_walk();
    test_timestamp_cut();
    test_long_segment();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    // Drain outstanding reports, then let the block settle
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcpts_pkg.sv
src/tcp_timestamp_option_finder.sv
src/tcp_timestamp_option_finder_checker.sv
tb/tb_top.sv
